[sv/multimode_feedback_delay_core_assert.svh]
// Assertion macros for the multimode feedback delay core.
`ifndef MULTIMODE_FEEDBACK_DELAY_CORE_ASSERT_SVH
`define MULTIMODE_FEEDBACK_DELAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfd check failed");

`define MFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfd check failed");

`else

`define MFD_ASSERT_NOW(label, clk, rst, ante, cons)

`define MFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/mfd_pkg.sv]
// Shared types, constants and arithmetic helpers of the feedback delay core.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

   localparam int DELAY_DEPTH = 131072;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);

   localparam int SAMPLE_W   = 24;
   localparam int ENV_W      = 23;
   localparam int KIND_W     = 2;
   localparam int LEN_W      = 17;
   localparam int FB_W       = 15;
   localparam int MIX_W      = 16;
   localparam int THR_W      = 23;
   localparam int RC_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int GAIN_W = ENV_W + 1;
   localparam int DRY_W  = MIX_W + 1;

   localparam int FB_MAX  = 32440;
   localparam int UNITY15 = 32768;
   localparam int ENV_MAX = 2 ** ENV_W - 1;

   localparam int FB_SHIFT   = 15;
   localparam int REL_SHIFT  = 16;
   localparam int GAIN_SHIFT = 23;
   localparam int MIX_SHIFT  = 15;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_MONO,
      KIND_STEREO,
      KIND_PING_PONG,
      KIND_DUCK
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KIND,
      CSR_LENGTH,
      CSR_FEEDBACK,
      CSR_MIX,
      CSR_THRESHOLD,
      CSR_RELEASE,
      CSR_BYPASS
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_ENV,
      S_DIV,
      S_DUCK_L,
      S_DUCK_R,
      S_FB_L,
      S_FB_R,
      S_MIX_LD,
      S_MIX_LW,
      S_MIX_RD,
      S_MIX_RW,
      S_FIN,
      S_DONE
   } state_type;

   // add half, then floor shift
   function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                    input int unsigned s);
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(1) << (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [SAMPLE_W-1:0] res;
      if (v > SAT_HI) begin
         res = SAT_HI[SAMPLE_W-1:0];
      end else if (v < SAT_LO) begin
         res = SAT_LO[SAMPLE_W-1:0];
      end else begin
         res = v[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/mfd_div.sv]
// Restoring divider for the ducking gain, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "multimode_feedback_delay_core_assert.svh"

module mfd_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [mfd_pkg::ENV_W-1:0]    num,
   input  wire  [mfd_pkg::ENV_W-1:0]    den,
   output logic                         busy,
   output logic [mfd_pkg::ENV_W-1:0]    quot
);
   import mfd_pkg::*;

   localparam int CNT_W = $clog2(ENV_W + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ENV_W-1:0]    rem_ff, rem_in;
   logic [ENV_W-1:0]    den_ff, den_in;
   logic [ENV_W-1:0]    quot_ff, quot_in;
   logic [ENV_W:0]      rem_sh;
   logic                ge;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff, 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ENV_W);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? ENV_W'(rem_sh - {1'b0, den_ff}) : rem_sh[ENV_W-1:0];
         quot_in = {quot_ff[ENV_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

   `MFD_ASSERT_NEXT(a_div_start, clock, reset, start, busy_ff)
   `MFD_ASSERT_NEXT(a_div_end, clock, reset, busy_ff && cnt_ff == CNT_W'(1) && !start, !busy_ff)
   `MFD_ASSERT_NEXT(a_div_hold, clock, reset, !busy_ff && !start, $stable(quot_ff))

endmodule

`default_nettype wire

[sv/multimode_feedback_delay_core.sv]
// Top level of the multimode stereo feedback delay core.
//
// req_ carries one stereo sample pair per word, rsp_ returns one pair per word.
// csr_ writes one setting register per cycle; the user writes only while the
// core is idle; the core does not enforce it. After reset the core sweeps
// both delay memories to zero, one entry a cycle, with req_tready held low.
// All state lives in two single-port delay memories plus a write pointer and
// an envelope register; one shared 25x25 multiplier does every product.
// Each word goes from accept through S_READ, S_ENV, S_FB_L, S_FB_R, the
// four mix states, S_FIN and S_DONE; ducking adds S_DUCK_L and S_DUCK_R,
// plus S_DIV for the restoring divider when the envelope exceeds the
// threshold. Bypass goes from accept straight to S_DONE.
// A finished word waits in the output register; the core takes the next word
// meanwhile and holds its own result until rsp_tready frees the register.
// Bypass returns the input unchanged and leaves all state untouched.
`timescale 1ns / 1ps
`default_nettype none
`include "multimode_feedback_delay_core_assert.svh"

module multimode_feedback_delay_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // left_in [23:0], right_in [47:24]
   input  wire  [2*mfd_pkg::SAMPLE_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // left_out [23:0], right_out [47:24]
   output logic [2*mfd_pkg::SAMPLE_W-1:0]     rsp_tdata,
   input  wire                                csr_we,
   input  wire  [mfd_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  wire  [mfd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mfd_pkg::*;

   // settings
   kind_type                   kind_ff, kind_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [FB_W-1:0]            fb_ff, fb_in;
   logic [MIX_W-1:0]           mix_ff, mix_in;
   logic [THR_W-1:0]           thr_ff, thr_in;
   logic [RC_W-1:0]            rc_ff, rc_in;
   logic                       bypass_ff, bypass_in;

   // control
   state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic [ENV_W-1:0]           env_ff, env_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [SAMPLE_W-1:0] l_ff, l_in, r_ff, r_in;
   logic signed [SAMPLE_W-1:0] dl_ff, dl_in, dr_ff, dr_in;
   logic signed [SAMPLE_W-1:0] wl_ff, wl_in, wr_ff, wr_in;
   logic signed [SAMPLE_W-1:0] wdl_ff, wdl_in, wdr_ff, wdr_in;
   logic signed [SAMPLE_W-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic signed [SAMPLE_W-1:0] rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in, acc_ff, acc_in;
   logic [GAIN_W-1:0]          g_ff, g_in;

   // delay memories
   logic signed [SAMPLE_W-1:0] left_mem  [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] right_mem [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] mem_l_q_ff, mem_r_q_ff;
   logic                       mem_re, mem_l_we, mem_r_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wl, mem_wr;

   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic [ADDR_W-1:0]          dly, rd_addr;
   logic [FB_W-1:0]            fb_sat;
   logic [DRY_W-1:0]           mx_sat, dry;
   logic [SAMPLE_W-1:0]        abs_l, abs_r, lev_raw;
   logic [ENV_W-1:0]           lev, rel, env_new;
   logic signed [SAMPLE_W-1:0] avg, line_l;
   logic signed [ACC_W-1:0]    prod_x, mix_sum;
   logic                       div_start, div_busy;
   logic [ENV_W-1:0]           div_quot;

   mfd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (thr_ff),
      .den   (env_new),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_comb begin
      if (len_ff == '0) begin
         dly = ADDR_W'(1);
      end else if (32'(len_ff) > DELAY_DEPTH - 1) begin
         dly = ADDR_W'(DELAY_DEPTH - 1);
      end else begin
         dly = ADDR_W'(len_ff);
      end
      if (wp_ff >= dly) begin
         rd_addr = wp_ff - dly;
      end else begin
         rd_addr = ADDR_W'(32'(wp_ff) + DELAY_DEPTH - 32'(dly));
      end
      fb_sat = (32'(fb_ff) > FB_MAX) ? FB_W'(FB_MAX) : fb_ff;
      mx_sat = (32'(mix_ff) > UNITY15) ? DRY_W'(UNITY15) : DRY_W'(mix_ff);
      dry    = DRY_W'(UNITY15) - mx_sat;
      abs_l  = l_ff[SAMPLE_W-1] ? SAMPLE_W'(-l_ff) : SAMPLE_W'(l_ff);
      abs_r  = r_ff[SAMPLE_W-1] ? SAMPLE_W'(-r_ff) : SAMPLE_W'(r_ff);
      lev_raw = (abs_l > abs_r) ? abs_l : abs_r;
      lev    = (32'(lev_raw) > ENV_MAX) ? ENV_W'(ENV_MAX) : lev_raw[ENV_W-1:0];
      avg    = SAMPLE_W'((ACC_W'(l_ff) + ACC_W'(r_ff)) >>> 1);
      line_l = (kind_ff == KIND_MONO) ? avg : l_ff;
      prod_x = ACC_W'(prod_ff);
      mix_sum = ACC_W'(acc_ff) + prod_x;
      rel    = ENV_W'(rshr(prod_x, REL_SHIFT));
      env_new = (lev > env_ff) ? lev : env_ff - rel;
   end

   always_comb begin
      case (state_ff)
         S_READ: begin
            mul_a = MUL_W'(env_ff - lev);
            mul_b = MUL_W'(rc_ff);
         end
         S_DUCK_L: begin
            mul_a = MUL_W'(dl_ff);
            mul_b = MUL_W'(g_ff);
         end
         S_DUCK_R: begin
            mul_a = MUL_W'(dr_ff);
            mul_b = MUL_W'(g_ff);
         end
         S_FB_L: begin
            mul_a = MUL_W'(wl_ff);
            mul_b = MUL_W'(fb_sat);
         end
         S_FB_R: begin
            mul_a = MUL_W'(wr_ff);
            mul_b = MUL_W'(fb_sat);
         end
         S_MIX_LD: begin
            mul_a = MUL_W'(l_ff);
            mul_b = MUL_W'(dry);
         end
         S_MIX_LW: begin
            mul_a = MUL_W'(wl_ff);
            mul_b = MUL_W'(mx_sat);
         end
         S_MIX_RD: begin
            mul_a = MUL_W'(r_ff);
            mul_b = MUL_W'(dry);
         end
         S_MIX_RW: begin
            mul_a = MUL_W'(wr_ff);
            mul_b = MUL_W'(mx_sat);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      kind_in      = kind_ff;
      len_in       = len_ff;
      fb_in        = fb_ff;
      mix_in       = mix_ff;
      thr_in       = thr_ff;
      rc_in        = rc_ff;
      bypass_in    = bypass_ff;
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wp_in        = wp_ff;
      env_in       = env_ff;
      rsp_valid_in = rsp_valid_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      wdl_in       = wdl_ff;
      wdr_in       = wdr_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      acc_in       = acc_ff;
      g_in         = g_ff;
      prod_in      = mul_a * mul_b;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      mem_re       = 1'b0;
      mem_l_we     = 1'b0;
      mem_r_we     = 1'b0;
      mem_waddr    = wp_ff;
      mem_wl       = wdl_ff;
      mem_wr       = wdr_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_KIND:      kind_in   = kind_type'(csr_wdata[KIND_W-1:0]);
            CSR_LENGTH:    len_in    = csr_wdata[LEN_W-1:0];
            CSR_FEEDBACK:  fb_in     = csr_wdata[FB_W-1:0];
            CSR_MIX:       mix_in    = csr_wdata[MIX_W-1:0];
            CSR_THRESHOLD: thr_in    = csr_wdata[THR_W-1:0];
            CSR_RELEASE:   rc_in     = csr_wdata[RC_W-1:0];
            CSR_BYPASS:    bypass_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_l_we    = 1'b1;
            mem_r_we    = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wl      = '0;
            mem_wr      = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (32'(clr_addr_ff) == DELAY_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               l_in = req_tdata[SAMPLE_W-1:0];
               r_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
               if (bypass_ff) begin
                  out_l_in = req_tdata[SAMPLE_W-1:0];
                  out_r_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_ENV;
         end
         S_ENV: begin
            if (kind_ff == KIND_DUCK) begin
               env_in = env_new;
               dl_in  = mem_l_q_ff;
               dr_in  = mem_r_q_ff;
               if (env_new > thr_ff) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  g_in     = GAIN_W'(1) << GAIN_SHIFT;
                  state_in = S_DUCK_L;
               end
            end else begin
               wl_in    = (kind_ff == KIND_PING_PONG) ? mem_r_q_ff : mem_l_q_ff;
               wr_in    = (kind_ff == KIND_STEREO) ? mem_r_q_ff : mem_l_q_ff;
               state_in = S_FB_L;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               g_in     = GAIN_W'(div_quot);
               state_in = S_DUCK_L;
            end
         end
         S_DUCK_L: begin
            state_in = S_DUCK_R;
         end
         S_DUCK_R: begin
            wl_in    = SAMPLE_W'(rshr(prod_x, GAIN_SHIFT));
            state_in = S_FB_L;
         end
         S_FB_L: begin
            if (kind_ff == KIND_DUCK) begin
               wr_in = SAMPLE_W'(rshr(prod_x, GAIN_SHIFT));
            end
            state_in = S_FB_R;
         end
         S_FB_R: begin
            wdl_in   = sat24(ACC_W'(line_l) + rshr(prod_x, FB_SHIFT));
            state_in = S_MIX_LD;
         end
         S_MIX_LD: begin
            wdr_in   = sat24(ACC_W'(r_ff) + rshr(prod_x, FB_SHIFT));
            state_in = S_MIX_LW;
         end
         S_MIX_LW: begin
            acc_in   = prod_ff;
            state_in = S_MIX_RD;
         end
         S_MIX_RD: begin
            out_l_in = sat24(rshr(mix_sum, MIX_SHIFT));
            state_in = S_MIX_RW;
         end
         S_MIX_RW: begin
            acc_in   = prod_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            out_r_in = sat24(rshr(mix_sum, MIX_SHIFT));
            mem_l_we = 1'b1;
            mem_r_we = (kind_ff != KIND_MONO);
            wp_in    = (32'(wp_ff) == DELAY_DEPTH - 1) ? '0 : wp_ff + ADDR_W'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = out_l_ff;
               rsp_r_in     = out_r_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_STEREO;
         len_ff       <= LEN_W'(12000);
         fb_ff        <= FB_W'(9830);
         mix_ff       <= MIX_W'(9830);
         thr_ff       <= THR_W'(528482);
         rc_ff        <= RC_W'(7);
         bypass_ff    <= 1'b0;
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         fb_ff        <= fb_in;
         mix_ff       <= mix_in;
         thr_ff       <= thr_in;
         rc_ff        <= rc_in;
         bypass_ff    <= bypass_in;
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      l_ff     <= l_in;
      r_ff     <= r_in;
      dl_ff    <= dl_in;
      dr_ff    <= dr_in;
      wl_ff    <= wl_in;
      wr_ff    <= wr_in;
      wdl_ff   <= wdl_in;
      wdr_ff   <= wdr_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      rsp_l_ff <= rsp_l_in;
      rsp_r_ff <= rsp_r_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      g_ff     <= g_in;
   end

   always_ff @(posedge clock) begin
      if (mem_l_we) begin
         left_mem[mem_waddr] <= mem_wl;
      end
      if (mem_re) begin
         mem_l_q_ff <= left_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_r_we) begin
         right_mem[mem_waddr] <= mem_wr;
      end
      if (mem_re) begin
         mem_r_q_ff <= right_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_r_ff, rsp_l_ff};

   `MFD_ASSERT_NEXT(a_wp_hold, clock, reset, state_ff != S_FIN, $stable(wp_ff))
   `MFD_ASSERT_NEXT(a_env_hold, clock, reset, state_ff != S_ENV, $stable(env_ff))
   `MFD_ASSERT_NOW(a_div_owner, clock, reset, div_busy, state_ff == S_DIV)
   `MFD_ASSERT_NEXT(a_rsp_load, clock, reset, state_ff == S_DONE && (!rsp_valid_ff || rsp_tready), rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
